[hw/rtl/sao_pkg.sv]
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared types, field widths and codes of the slab object allocator.
// ----------------------------------------------------------------------------
package sao_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int LINK_W     = 7;
    localparam int SLAB_W     = 6;
    localparam int OFF_W      = 12;
    localparam int SLOT_W     = 9;
    localparam int CNT_W      = 10;
    localparam int FREE_W     = 10;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int PAD_W      = 14;
    localparam int DIV_W      = 12;
    localparam int PROD_W     = 24;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = 6;

    localparam logic [LINK_W-1:0] NIL_LINK = 7'd127;
    localparam logic [FREE_W-1:0] FREE_MAX = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_ALIGN = 1'd1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_NO_SLAB      = 3'd1,
        STATUS_TOO_LARGE    = 3'd2,
        STATUS_INVALID_FREE = 3'd3,
        STATUS_DOUBLE_FREE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_FULL    = 2'd2,
        KIND_EMPTY   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LAY_INIT,
        ST_LAY_DIV,
        ST_LAY_MIN,
        ST_LAY_MUL,
        ST_LAY_CHK,
        ST_DISPATCH,
        ST_A_PART,
        ST_A_EMPTY,
        ST_A_CLEAR,
        ST_A_READ,
        ST_A_SCAN,
        ST_A_UPDATE,
        ST_A_FINISH,
        ST_F_DIV,
        ST_F_CHECK,
        ST_F_BIT,
        ST_F_WALK_RD,
        ST_F_WALK_CHK,
        ST_F_PUSH
    } state_t;

    typedef struct packed {
        logic              req_type;
        logic [SLAB_W-1:0] slab_index;
        logic [OFF_W-1:0]  page_offset;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLAB_W-1:0] result_slab;
        logic [OFF_W-1:0]  result_offset;
        logic [SLOT_W-1:0] result_slot;
        logic              page_released;
    } res_t;

    typedef struct packed {
        kind_t             kind;
        logic [FREE_W-1:0] free_slots;
        logic [LINK_W-1:0] link;
    } meta_t;

endpackage

[hw/rtl/slab_object_allocator.sv]
// ----------------------------------------------------------------------------
// Slab object allocator
// One object cache: alloc and free of fixed-size objects in slab pages.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result is
// shown on res for exactly one cycle with done high and cannot be held off.
// One transaction is in flight at a time. An alloc from a live partial slab
// scans its bitmap words in turn, 1 to MAX_SLOTS/64 of them; a newly created
// slab first has every bitmap word cleared. A free runs a 12-step divider
// for the slot index, adds a push step when the slab changes list, and walks
// the list node by node to unlink the slab. The first transaction after reset
// or a register write recomputes the layout, decrementing the slot count
// until the objects fit. Slab state lives in a 64-bit-wide bitmap memory and
// a metadata memory, each with a registered read port.
// ----------------------------------------------------------------------------
module slab_object_allocator #(
    parameter int NUM_SLABS    = 64,
    parameter int MAX_SLOTS    = 512,
    parameter int HEADER_BYTES = 24,
    parameter int EMPTY_KEEP   = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sao_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sao_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  sao_pkg::req_t              req,
    output logic                       done,
    output sao_pkg::res_t              res
);
    import sao_pkg::*;

    localparam int WPS      = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW      = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int SLAB_AW  = $clog2(NUM_SLABS);
    localparam int BM_DEPTH = NUM_SLABS * WPS;
    localparam int BAW      = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
    localparam int ECW      = (EMPTY_KEEP > 0) ? $clog2(EMPTY_KEEP + 1) : 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  ob_reg, ob_next, oa_reg, oa_next;
    logic              dirty_reg, dirty_next;
    logic [CFG_W-1:0]  align_reg, align_next;
    logic [PAD_W-1:0]  padded_reg, padded_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PAD_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [PAD_W-1:0]  doff_reg, doff_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    logic [DIV_W-1:0]  q_reg, q_next;
    logic [PAD_W-1:0]  rem_reg, rem_next;
    logic [PAD_W-1:0]  dsr_reg, dsr_next;
    logic [3:0]        dcnt_reg, dcnt_next;

    logic [LINK_W-1:0] ph_reg, ph_next, fh_reg, fh_next, eh_reg, eh_next;
    logic [LINK_W-1:0] nn_reg, nn_next;
    logic [ECW-1:0]    ecnt_reg, ecnt_next;

    req_t              req_reg, req_next;
    logic [LINK_W-1:0] s_reg, s_next;
    logic [LINK_W-1:0] link_reg, link_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [FREE_W-1:0] free_reg, free_next;
    logic              from_full_reg, from_full_next;
    logic [WAW-1:0]    w_reg, w_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              done_reg, done_next;
    res_t              res_reg, res_next;

    meta_t             meta_mem [NUM_SLABS];
    meta_t             meta_rd_reg;
    logic              meta_we, meta_re;
    logic [SLAB_AW-1:0] meta_waddr, meta_raddr;
    meta_t             meta_wdata;

    logic [WORD_BITS-1:0] bm_mem [BM_DEPTH];
    logic [WORD_BITS-1:0] bm_rd_reg;
    logic              bm_we, bm_re;
    logic [BAW-1:0]    bm_addr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic [WAW-1:0]    w_sel;

    logic [CFG_W-1:0]  align_c;
    logic [PAD_W-1:0]  padded_c;
    logic [PAD_W:0]    div_trial;
    logic              div_ge;
    logic [PAD_W-1:0]  div_rem;
    logic              div_last;

    logic              scan_found;
    logic [BIT_W-1:0]  scan_pos;
    logic [CNT_W-1:0]  scan_base, scan_lim;
    logic              scan_last;

    logic [FREE_W-1:0] fnew;
    logic [LINK_W-1:0] kind_head;
    logic [OFF_W-1:0]  rel_c;

    function automatic logic [PAD_W-1:0] data_off(input logic [CNT_W-1:0] n,
                                                  input logic [CFG_W-1:0] a);
        logic [PAD_W-1:0] t;
        logic [PAD_W-1:0] m;
        t = PAD_W'(HEADER_BYTES) + PAD_W'((n + CNT_W'(7)) >> 3);
        m = PAD_W'(a) - PAD_W'(1);
        return (t + m) & ~m;
    endfunction

    function automatic res_t make_res(input status_t st, input logic [LINK_W-1:0] slab,
                                      input logic [OFF_W-1:0] off,
                                      input logic [SLOT_W-1:0] slot, input logic rel);
        res_t r;
        r.status        = st;
        r.result_slab   = slab[SLAB_W-1:0];
        r.result_offset = off;
        r.result_slot   = slot;
        r.page_released = rel;
        return r;
    endfunction

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

    always_comb
    begin
        align_c = CFG_W'(8);
        for (int k = 3; k < CFG_W; k++)
        begin
            if (oa_reg[k])
            begin
                align_c = CFG_W'(1) << k;
            end
        end
        padded_c = (PAD_W'(ob_reg) + PAD_W'(align_c) - PAD_W'(1))
                   & ~(PAD_W'(align_c) - PAD_W'(1));
    end

    always_comb
    begin
        div_trial = {rem_reg, q_reg[DIV_W-1]};
        div_ge    = (div_trial >= {1'b0, dsr_reg});
        div_rem   = div_ge ? PAD_W'(div_trial - {1'b0, dsr_reg}) : div_trial[PAD_W-1:0];
        div_last  = (dcnt_reg == 4'(DIV_W - 1));
    end

    always_comb
    begin
        scan_found = 1'b0;
        scan_pos   = '0;
        scan_base  = CNT_W'(w_reg) << BIT_W;
        scan_lim   = count_reg - scan_base;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if ((CNT_W'(b) < scan_lim) && !bm_rd_reg[b])
            begin
                scan_found = 1'b1;
                scan_pos   = BIT_W'(b);
            end
        end
        scan_last = ((CNT_W + 1)'(scan_base) + (CNT_W + 1)'(WORD_BITS))
                    >= (CNT_W + 1)'(count_reg);
    end

    always_comb
    begin
        fnew = (meta_rd_reg.free_slots < FREE_MAX) ? meta_rd_reg.free_slots + FREE_W'(1)
                                                   : meta_rd_reg.free_slots;
        case (meta_rd_reg.kind)
            KIND_PARTIAL: kind_head = ph_reg;
            KIND_FULL:    kind_head = fh_reg;
            KIND_EMPTY:   kind_head = eh_reg;
            default:      kind_head = NIL_LINK;
        endcase
        rel_c = req_reg.page_offset - base_reg[OFF_W-1:0];
        case (state_reg)
            ST_F_CHECK: w_sel = WAW'(q_reg[SLOT_W-1:BIT_W]);
            ST_F_BIT:   w_sel = WAW'(slot_reg[SLOT_W-1:BIT_W]);
            default:    w_sel = w_reg;
        endcase
        bm_addr = BAW'(int'(s_reg[SLAB_AW-1:0]) * WPS + int'(w_sel));
    end

    always_comb
    begin
        state_next    = state_reg;
        ob_next       = ob_reg;
        oa_next       = oa_reg;
        dirty_next    = dirty_reg;
        align_next    = align_reg;
        padded_next   = padded_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        n_next        = n_reg;
        doff_next     = doff_reg;
        prod_next     = prod_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        dcnt_next     = dcnt_reg;
        ph_next       = ph_reg;
        fh_next       = fh_reg;
        eh_next       = eh_reg;
        nn_next       = nn_reg;
        ecnt_next     = ecnt_reg;
        req_next      = req_reg;
        s_next        = s_reg;
        link_next     = link_reg;
        cur_next      = cur_reg;
        free_next     = free_reg;
        from_full_next = from_full_reg;
        w_next        = w_reg;
        slot_next     = slot_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        meta_we       = 1'b0;
        meta_re       = 1'b0;
        meta_waddr    = s_reg[SLAB_AW-1:0];
        meta_raddr    = s_reg[SLAB_AW-1:0];
        meta_wdata    = meta_rd_reg;
        bm_we         = 1'b0;
        bm_re         = 1'b0;
        bm_wdata      = '0;

        if (cfg_we)
        begin
            dirty_next = 1'b1;
            unique case (cfg_index)
                REG_OBJECT_BYTES: ob_next = cfg_data;
                REG_OBJECT_ALIGN: oa_next = cfg_data;
            endcase
        end

        if (state_reg == ST_LAY_DIV || state_reg == ST_F_DIV)
        begin
            rem_next  = div_rem;
            q_next    = {q_reg[DIV_W-2:0], div_ge};
            dcnt_next = dcnt_reg + 4'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = dirty_reg ? ST_LAY_INIT : ST_DISPATCH;
                end
            end
            ST_LAY_INIT:
            begin
                align_next  = align_c;
                padded_next = padded_c;
                if (padded_c == '0)
                begin
                    count_next = '0;
                    dirty_next = 1'b0;
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    q_next     = DIV_W'(PAGE_BYTES - HEADER_BYTES);
                    rem_next   = '0;
                    dsr_next   = padded_c + PAD_W'(1);
                    dcnt_next  = '0;
                    state_next = ST_LAY_DIV;
                end
            end
            ST_LAY_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_LAY_MIN;
                end
            end
            ST_LAY_MIN:
            begin
                n_next = (q_reg > DIV_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(q_reg);
                state_next = ST_LAY_MUL;
            end
            ST_LAY_MUL:
            begin
                prod_next  = PROD_W'(n_reg) * PROD_W'(padded_reg);
                doff_next  = data_off(n_reg, align_reg);
                state_next = ST_LAY_CHK;
            end
            ST_LAY_CHK:
            begin
                if ((n_reg != '0) &&
                    ((PROD_W + 1)'(doff_reg) + (PROD_W + 1)'(prod_reg)
                     > (PROD_W + 1)'(PAGE_BYTES)))
                begin
                    n_next     = n_reg - CNT_W'(1);
                    state_next = ST_LAY_MUL;
                end
                else
                begin
                    count_next = n_reg;
                    base_next  = doff_reg;
                    dirty_next = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (req_reg.req_type == REQ_ALLOC)
                begin
                    if (count_reg == '0)
                    begin
                        res_next   = make_res(STATUS_TOO_LARGE, '0, '0, '0, 1'b0);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (ph_reg < LINK_W'(NUM_SLABS))
                    begin
                        s_next     = ph_reg;
                        meta_re    = 1'b1;
                        meta_raddr = ph_reg[SLAB_AW-1:0];
                        state_next = ST_A_PART;
                    end
                    else if (eh_reg < LINK_W'(NUM_SLABS))
                    begin
                        s_next     = eh_reg;
                        meta_re    = 1'b1;
                        meta_raddr = eh_reg[SLAB_AW-1:0];
                        state_next = ST_A_EMPTY;
                    end
                    else if (nn_reg < LINK_W'(NUM_SLABS))
                    begin
                        s_next     = nn_reg;
                        nn_next    = nn_reg + LINK_W'(1);
                        meta_we    = 1'b1;
                        meta_waddr = nn_reg[SLAB_AW-1:0];
                        meta_wdata = '{kind: KIND_PARTIAL, free_slots: count_reg, link: ph_reg};
                        link_next  = ph_reg;
                        ph_next    = nn_reg;
                        free_next  = count_reg;
                        w_next     = '0;
                        state_next = ST_A_CLEAR;
                    end
                    else
                    begin
                        res_next   = make_res(STATUS_NO_SLAB, '0, '0, '0, 1'b0);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if ((count_reg == '0) ||
                        (LINK_W'(req_reg.slab_index) >= LINK_W'(NUM_SLABS)) ||
                        (LINK_W'(req_reg.slab_index) >= nn_reg) ||
                        (PAD_W'(req_reg.page_offset) < base_reg))
                    begin
                        res_next   = make_res(STATUS_INVALID_FREE, '0, '0, '0, 1'b0);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        s_next     = LINK_W'(req_reg.slab_index);
                        meta_re    = 1'b1;
                        meta_raddr = SLAB_AW'(req_reg.slab_index);
                        q_next     = rel_c;
                        rem_next   = '0;
                        dsr_next   = padded_reg;
                        dcnt_next  = '0;
                        state_next = ST_F_DIV;
                    end
                end
            end
            ST_A_PART:
            begin
                free_next  = meta_rd_reg.free_slots;
                link_next  = meta_rd_reg.link;
                w_next     = '0;
                state_next = ST_A_READ;
            end
            ST_A_EMPTY:
            begin
                eh_next    = meta_rd_reg.link;
                ecnt_next  = ecnt_reg - ECW'(1);
                meta_we    = 1'b1;
                meta_wdata = '{kind: KIND_PARTIAL, free_slots: meta_rd_reg.free_slots,
                               link: ph_reg};
                link_next  = ph_reg;
                ph_next    = s_reg;
                free_next  = meta_rd_reg.free_slots;
                w_next     = '0;
                state_next = ST_A_READ;
            end
            ST_A_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_wdata = '0;
                if (w_reg == WAW'(WPS - 1))
                begin
                    w_next     = '0;
                    state_next = ST_A_READ;
                end
                else
                begin
                    w_next = w_reg + WAW'(1);
                end
            end
            ST_A_READ:
            begin
                bm_re      = 1'b1;
                state_next = ST_A_SCAN;
            end
            ST_A_SCAN:
            begin
                if (scan_found)
                begin
                    slot_next  = (SLOT_W'(w_reg) << BIT_W) | SLOT_W'(scan_pos);
                    bm_we      = 1'b1;
                    bm_wdata   = bm_rd_reg | (WORD_BITS'(1) << scan_pos);
                    state_next = ST_A_UPDATE;
                end
                else if (scan_last)
                begin
                    ph_next    = link_reg;
                    meta_we    = 1'b1;
                    meta_wdata = '{kind: KIND_FULL, free_slots: '0, link: fh_reg};
                    fh_next    = s_reg;
                    res_next   = make_res(STATUS_NO_SLAB, '0, '0, '0, 1'b0);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    w_next     = w_reg + WAW'(1);
                    state_next = ST_A_READ;
                end
            end
            ST_A_UPDATE:
            begin
                prod_next = PROD_W'(slot_reg) * PROD_W'(padded_reg);
                meta_we   = 1'b1;
                if (free_reg <= FREE_W'(1))
                begin
                    ph_next    = link_reg;
                    meta_wdata = '{kind: KIND_FULL, free_slots: '0, link: fh_reg};
                    fh_next    = s_reg;
                end
                else
                begin
                    meta_wdata = '{kind: KIND_PARTIAL, free_slots: free_reg - FREE_W'(1),
                                   link: link_reg};
                end
                state_next = ST_A_FINISH;
            end
            ST_A_FINISH:
            begin
                res_next   = make_res(STATUS_OK, s_reg,
                                      OFF_W'(PROD_W'(base_reg) + prod_reg), slot_reg, 1'b0);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_F_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_F_CHECK;
                end
            end
            ST_F_CHECK:
            begin
                if ((meta_rd_reg.kind == KIND_NONE) || (rem_reg != '0) ||
                    (q_reg >= DIV_W'(count_reg)))
                begin
                    res_next   = make_res(STATUS_INVALID_FREE, '0, '0, '0, 1'b0);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next  = SLOT_W'(q_reg);
                    bm_re      = 1'b1;
                    state_next = ST_F_BIT;
                end
            end
            ST_F_BIT:
            begin
                if (!bm_rd_reg[slot_reg[BIT_W-1:0]])
                begin
                    res_next   = make_res(STATUS_DOUBLE_FREE, '0, '0, slot_reg, 1'b0);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    bm_we         = 1'b1;
                    bm_wdata      = bm_rd_reg & ~(WORD_BITS'(1) << slot_reg[BIT_W-1:0]);
                    link_next     = meta_rd_reg.link;
                    free_next     = fnew;
                    from_full_next = (meta_rd_reg.free_slots == '0);
                    if ((meta_rd_reg.free_slots == '0) || (fnew >= FREE_W'(count_reg)))
                    begin
                        if (meta_rd_reg.kind == KIND_EMPTY)
                        begin
                            ecnt_next = ecnt_reg - ECW'(1);
                        end
                        if (kind_head == s_reg)
                        begin
                            case (meta_rd_reg.kind)
                                KIND_PARTIAL: ph_next = meta_rd_reg.link;
                                KIND_FULL:    fh_next = meta_rd_reg.link;
                                KIND_EMPTY:   eh_next = meta_rd_reg.link;
                                default:      ph_next = ph_reg;
                            endcase
                            state_next = ST_F_PUSH;
                        end
                        else
                        begin
                            cur_next   = kind_head;
                            state_next = ST_F_WALK_RD;
                        end
                    end
                    else
                    begin
                        meta_we    = 1'b1;
                        meta_wdata = '{kind: meta_rd_reg.kind, free_slots: fnew,
                                       link: meta_rd_reg.link};
                        res_next   = make_res(STATUS_OK, '0, '0, slot_reg, 1'b0);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_F_WALK_RD:
            begin
                if (cur_reg >= LINK_W'(NUM_SLABS))
                begin
                    state_next = ST_F_PUSH;
                end
                else
                begin
                    meta_re    = 1'b1;
                    meta_raddr = cur_reg[SLAB_AW-1:0];
                    state_next = ST_F_WALK_CHK;
                end
            end
            ST_F_WALK_CHK:
            begin
                if (meta_rd_reg.link == s_reg)
                begin
                    meta_we    = 1'b1;
                    meta_waddr = cur_reg[SLAB_AW-1:0];
                    meta_wdata = '{kind: meta_rd_reg.kind, free_slots: meta_rd_reg.free_slots,
                                   link: link_reg};
                    state_next = ST_F_PUSH;
                end
                else
                begin
                    cur_next   = meta_rd_reg.link;
                    state_next = ST_F_WALK_RD;
                end
            end
            ST_F_PUSH:
            begin
                meta_we    = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (from_full_reg)
                begin
                    meta_wdata = '{kind: KIND_PARTIAL, free_slots: free_reg, link: ph_reg};
                    ph_next    = s_reg;
                    res_next   = make_res(STATUS_OK, '0, '0, slot_reg, 1'b0);
                end
                else if (ecnt_reg < ECW'(EMPTY_KEEP))
                begin
                    meta_wdata = '{kind: KIND_EMPTY, free_slots: free_reg, link: eh_reg};
                    eh_next    = s_reg;
                    ecnt_next  = ecnt_reg + ECW'(1);
                    res_next   = make_res(STATUS_OK, '0, '0, slot_reg, 1'b0);
                end
                else
                begin
                    meta_wdata = '{kind: KIND_NONE, free_slots: '0, link: NIL_LINK};
                    res_next   = make_res(STATUS_OK, '0, '0, slot_reg, 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_reg    <= CFG_W'(64);
            oa_reg    <= CFG_W'(8);
            dirty_reg <= 1'b1;
            ph_reg    <= NIL_LINK;
            fh_reg    <= NIL_LINK;
            eh_reg    <= NIL_LINK;
            nn_reg    <= '0;
            ecnt_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ob_reg    <= ob_next;
            oa_reg    <= oa_next;
            dirty_reg <= dirty_next;
            ph_reg    <= ph_next;
            fh_reg    <= fh_next;
            eh_reg    <= eh_next;
            nn_reg    <= nn_next;
            ecnt_reg  <= ecnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        align_reg    <= align_next;
        padded_reg   <= padded_next;
        count_reg    <= count_next;
        base_reg     <= base_next;
        n_reg        <= n_next;
        doff_reg     <= doff_next;
        prod_reg     <= prod_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        dcnt_reg     <= dcnt_next;
        req_reg      <= req_next;
        s_reg        <= s_next;
        link_reg     <= link_next;
        cur_reg      <= cur_next;
        free_reg     <= free_next;
        from_full_reg <= from_full_next;
        w_reg        <= w_next;
        slot_reg     <= slot_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (meta_re)
        begin
            meta_rd_reg <= meta_mem[meta_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_addr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rd_reg <= bm_mem[bm_addr];
        end
    end

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_meta_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (meta_we && meta_re) |-> (meta_waddr != meta_raddr))
        else $error("metadata read and write to the same slab in one cycle");

    a_bm_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(bm_we && bm_re))
        else $error("bitmap read and write in one cycle");

    a_new_slab_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (nn_reg <= LINK_W'(NUM_SLABS)) && (ecnt_reg <= ECW'(EMPTY_KEEP)))
        else $error("slab counter or empty list count out of range");

endmodule

[dv/slab_object_allocator_tb.sv]
// ----------------------------------------------------------------------------
// Slab object allocator testbench
// Drives alloc and free transactions through several object layouts and
// compares every result with an in-bench prediction of the slab lists,
// bitmaps and counters.
// ----------------------------------------------------------------------------
module slab_object_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sao_pkg::*;

    localparam int SLABS = 64;
    localparam int SLOTS = 512;
    localparam int HDR   = 24;
    localparam int KEEP  = 2;
    localparam int NIL   = 127;

    typedef struct {
        int slab;
        int offset;
    } obj_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    req_t                 req;
    logic                 done;
    res_t                 res;

    // allocator image
    bit     slot_map [SLABS][SLOTS];
    int     free_cnt [SLABS];
    kind_t  slab_kind [SLABS];
    int     next_link [SLABS];
    int     list_head [4];
    int     new_slab;
    int     obj_bytes;
    int     obj_align;
    int     lay_align;
    int     lay_padded;
    int     lay_count;

    res_t   pending_res[$];
    obj_t   live_objs[$];
    obj_t   freed_objs[$];
    int     errors;
    int     status_seen [5];
    int     releases;
    bit     idle_on;

    slab_object_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .res       (res)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int round_up(int v, int a);
        return (v + a - 1) / a * a;
    endfunction

    function automatic int obj_start(int n);
        return round_up(HDR + (n + 7) / 8, lay_align);
    endfunction

    function automatic void derive_layout();
        int a;
        int n;
        a = 8;
        while (a <= 2048 && (a * 2) <= obj_align)
            a = a * 2;
        lay_align = a;
        lay_padded = round_up(obj_bytes, a);
        lay_count = 0;
        if (lay_padded == 0)
            return;
        n = (PAGE_BYTES - HDR) / (lay_padded + 1);
        if (n > SLOTS)
            n = SLOTS;
        while (n > 0 && obj_start(n) + n * lay_padded > PAGE_BYTES)
            n--;
        lay_count = n;
    endfunction

    function automatic void unlink_slab(int s);
        int prev;
        int cur;
        int steps;
        if (slab_kind[s] == KIND_NONE)
            return;
        prev = -1;
        cur = list_head[slab_kind[s]];
        steps = 0;
        while (cur != NIL && steps <= SLABS) begin
            if (cur == s) begin
                if (prev < 0)
                    list_head[slab_kind[s]] = next_link[s];
                else
                    next_link[prev] = next_link[s];
                break;
            end
            if (cur >= SLABS)
                break;
            prev = cur;
            cur = next_link[cur];
            steps++;
        end
        next_link[s] = NIL;
        slab_kind[s] = KIND_NONE;
    endfunction

    function automatic void push_slab(int s, kind_t k);
        slab_kind[s] = k;
        next_link[s] = list_head[k];
        list_head[k] = s;
    endfunction

    function automatic int empty_list_len();
        int n;
        int cur;
        n = 0;
        cur = list_head[KIND_EMPTY];
        while (cur < SLABS && n <= SLABS) begin
            n++;
            cur = next_link[cur];
        end
        return n;
    endfunction

    function automatic void clear_slab(int s);
        for (int i = 0; i < SLOTS; i++)
            slot_map[s][i] = 1'b0;
    endfunction

    function automatic res_t allocate_object();
        res_t r;
        int   s;
        int   i;
        r = '0;
        r.status = STATUS_OK;
        if (lay_count == 0) begin
            r.status = STATUS_TOO_LARGE;
            return r;
        end
        s = list_head[KIND_PARTIAL];
        if (s >= SLABS) begin
            if (list_head[KIND_EMPTY] < SLABS) begin
                s = list_head[KIND_EMPTY];
                unlink_slab(s);
                push_slab(s, KIND_PARTIAL);
            end
            else if (new_slab < SLABS) begin
                s = new_slab;
                new_slab++;
                clear_slab(s);
                free_cnt[s] = lay_count;
                push_slab(s, KIND_PARTIAL);
            end
            else begin
                r.status = STATUS_NO_SLAB;
                return r;
            end
        end
        for (i = 0; i < lay_count; i++)
            if (!slot_map[s][i])
                break;
        if (i >= lay_count) begin
            free_cnt[s] = 0;
            unlink_slab(s);
            push_slab(s, KIND_FULL);
            r.status = STATUS_NO_SLAB;
            return r;
        end
        slot_map[s][i] = 1'b1;
        if (free_cnt[s] > 0)
            free_cnt[s]--;
        r.result_slab = SLAB_W'(s);
        r.result_slot = SLOT_W'(i);
        r.result_offset = OFF_W'(obj_start(lay_count) + i * lay_padded);
        if (free_cnt[s] == 0) begin
            unlink_slab(s);
            push_slab(s, KIND_FULL);
        end
        return r;
    endfunction

    function automatic res_t free_object(int s, int off);
        res_t r;
        int   base;
        int   rel;
        int   idx;
        bit   from_full;
        r = '0;
        r.status = STATUS_INVALID_FREE;
        if (slab_kind[s] == KIND_NONE || lay_count == 0)
            return r;
        base = obj_start(lay_count);
        if (off < base)
            return r;
        rel = off - base;
        if (rel % lay_padded != 0 || rel / lay_padded >= lay_count)
            return r;
        idx = rel / lay_padded;
        r.result_slot = SLOT_W'(idx);
        if (!slot_map[s][idx]) begin
            r.status = STATUS_DOUBLE_FREE;
            return r;
        end
        r.status = STATUS_OK;
        slot_map[s][idx] = 1'b0;
        from_full = (free_cnt[s] == 0);
        if (free_cnt[s] < 1023)
            free_cnt[s]++;
        if (from_full) begin
            unlink_slab(s);
            push_slab(s, KIND_PARTIAL);
        end
        else if (free_cnt[s] >= lay_count) begin
            unlink_slab(s);
            if (empty_list_len() < KEEP)
                push_slab(s, KIND_EMPTY);
            else begin
                clear_slab(s);
                free_cnt[s] = 0;
                r.page_released = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic res_t predict_request(req_t r);
        derive_layout();
        if (r.req_type == REQ_ALLOC)
            return allocate_object();
        return free_object(r.slab_index, r.page_offset);
    endfunction

    task automatic send_request(req_t r, output res_t p);
        @(posedge clk);
        if (idle_on && $urandom_range(99) < 8)
            repeat ($urandom_range(1, 12)) @(posedge clk);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        start <= 1'b0;
        p = predict_request(r);
        pending_res.push_back(p);
        status_seen[p.status]++;
        if (p.page_released)
            releases++;
        if (p.status == STATUS_OK && r.req_type == REQ_ALLOC)
            live_objs.push_back('{int'(p.result_slab), int'(p.result_offset)});
    endtask

    task automatic alloc_one();
        req_t r;
        res_t p;
        r.req_type = REQ_ALLOC;
        r.slab_index = SLAB_W'($urandom);
        r.page_offset = OFF_W'($urandom);
        send_request(r, p);
    endtask

    task automatic free_at(int s, int off);
        req_t r;
        res_t p;
        r.req_type = REQ_FREE;
        r.slab_index = SLAB_W'(s);
        r.page_offset = OFF_W'(off);
        send_request(r, p);
    endtask

    task automatic free_live();
        int   k;
        obj_t o;
        if (live_objs.size() == 0) begin
            alloc_one();
            return;
        end
        k = $urandom_range(live_objs.size() - 1);
        o = live_objs[k];
        live_objs.delete(k);
        freed_objs.push_back(o);
        if (freed_objs.size() > 16)
            void'(freed_objs.pop_front());
        free_at(o.slab, o.offset);
    endtask

    task automatic wait_drain();
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(v);
        if (idx == REG_OBJECT_BYTES)
            obj_bytes = v;
        else
            obj_align = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_layout(int bytes, int align);
        wait_drain();
        write_reg(REG_OBJECT_BYTES, bytes);
        write_reg(REG_OBJECT_ALIGN, align);
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v,
                     act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && done) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, res);
                errors++;
            end
            else begin
                e = pending_res.pop_front();
                check_field("status", e.status, res.status);
                check_field("result_slab", e.result_slab, res.result_slab);
                check_field("result_offset", e.result_offset, res.result_offset);
                check_field("result_slot", e.result_slot, res.result_slot);
                check_field("page_released", e.page_released, res.page_released);
            end
        end
    end

    task automatic test_basic_alloc_free();
        obj_t o;
        repeat (4) alloc_one();
        o = live_objs.pop_front();
        free_at(o.slab, o.offset);
        free_at(o.slab, o.offset);
        alloc_one();
        while (live_objs.size() != 0)
            free_live();
    endtask

    task automatic test_bad_frees();
        alloc_one();
        free_at(0, 0);
        free_at(0, 4095);
        free_at(0, obj_start(lay_count) + 1);
        free_at(63, obj_start(lay_count));
        free_at(5, obj_start(lay_count));
    endtask

    task automatic test_layout_extremes();
        set_layout(0, 8);
        alloc_one();
        free_at(0, 64);
        set_layout(4096, 0);
        alloc_one();
        set_layout(1, 4096);
        alloc_one();
        set_layout(1, 3000);
        alloc_one();
        set_layout(4000, 8);
        alloc_one();
        while (live_objs.size() != 0)
            free_live();
    endtask

    task automatic test_register_change();
        set_layout(64, 8);
        repeat (10) alloc_one();
        set_layout(512, 8);
        alloc_one();
        alloc_one();
        set_layout(64, 8);
        while (live_objs.size() != 0)
            free_live();
    endtask

    task automatic random_phase(int items, int bytes, int align);
        obj_t o;
        set_layout(bytes, align);
        live_objs.delete();
        for (int n = 0; n < items; n++) begin
            idle_on = !(n >= items / 3 && n < items / 3 + 150);
            if (n == items / 2)
                wait_drain();
            case ($urandom_range(19))
                0: free_at($urandom, $urandom);
                1:
                begin
                    if (freed_objs.size() != 0) begin
                        o = freed_objs[$urandom_range(freed_objs.size() - 1)];
                        free_at(o.slab, o.offset);
                    end
                    else
                        alloc_one();
                end
                default:
                begin
                    if (live_objs.size() != 0 &&
                        ($urandom_range(99) < 45 || live_objs.size() > 40))
                        free_live();
                    else
                        alloc_one();
                end
            endcase
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        random_phase(450, 64, 8);
        random_phase(350, 512, 64);
        random_phase(250, 2048, 8);
        random_phase(200, 1024, 16);
        random_phase(250, $urandom_range(1, 300), 1 << $urandom_range(0, 7));
    endtask

    task automatic test_exhaustion();
        set_layout(4000, 8);
        repeat (70) alloc_one();
        repeat (3) free_live();
        repeat (4) alloc_one();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        req = '0;
        errors = 0;
        releases = 0;
        idle_on = 1'b1;
        obj_bytes = 64;
        obj_align = 8;
        new_slab = 0;
        for (int k = 0; k < 4; k++)
            list_head[k] = NIL;
        for (int s = 0; s < SLABS; s++) begin
            clear_slab(s);
            free_cnt[s] = 0;
            slab_kind[s] = KIND_NONE;
            next_link[s] = NIL;
        end
        for (int k = 0; k < 5; k++)
            status_seen[k] = 0;
        derive_layout();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_alloc_free();
        test_bad_frees();
        test_layout_extremes();
        test_register_change();
        test_random();
        test_exhaustion();
        wait_drain();
        $display("Covered %0d ok, %0d no-slab, %0d too-large, %0d invalid and %0d double frees,",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        $display("with %0d page releases over several object layouts.", releases);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

endmodule
